// ===== hw/rtl/wsfd_pkg.sv =====
// shared types and constants of the websocket frame deframer
`timescale 1ns / 1ps

package wsfd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 64;
    localparam int KIND_W   = 2;
    localparam int OPC_W    = 4;
    localparam int LEN7_W   = 7;
    localparam int HLEFT_W  = 4;
    localparam int KEY_W    = 32;
    localparam int MIDX_W   = 2;

    localparam logic [LEN7_W-1:0]  LEN16_CODE = 7'd126;
    localparam logic [LEN7_W-1:0]  LEN64_CODE = 7'd127;
    localparam logic [OPC_W-1:0]   OP_CONT    = 4'h0;
    localparam logic [OPC_W-1:0]   OP_BINARY  = 4'h2;
    localparam logic [OPC_W-1:0]   OP_CLOSE   = 4'h8;
    localparam logic [HLEFT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [HLEFT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [HLEFT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_CLOSE    = 2'd3
    } t_kind;

    typedef enum logic [6:0] {
        PH_HDR0    = 7'b0000001,
        PH_HDR1    = 7'b0000010,
        PH_EXTLEN  = 7'b0000100,
        PH_MASKKEY = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_SKIP    = 7'b0100000,
        PH_CLOSED  = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
        logic              message_end;
        logic [OPC_W-1:0]  message_type;
    } t_result;

endpackage

// ===== hw/rtl/wsfd_byte_if.sv =====
// byte stream channel into the deframer
`timescale 1ns / 1ps

interface wsfd_byte_if;
    import wsfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/wsfd_result_if.sv =====
// result channel out of the deframer
`timescale 1ns / 1ps

interface wsfd_result_if;
    import wsfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              message_end;
    logic [OPC_W-1:0]  message_type;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_last, output message_end, output message_type,
                    input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_last, input message_end, input message_type,
                    output ready);
endinterface

// ===== hw/rtl/wsfd_cfg_if.sv =====
// configuration write channel carrying the payload limit
`timescale 1ns / 1ps

interface wsfd_cfg_if;
    import wsfd_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] payload_limit;

    modport source (output valid, output payload_limit, input ready);
    modport sink   (input valid, input payload_limit, output ready);
endinterface

// ===== hw/rtl/wsfd_parser.sv =====
// frame header parser and payload unmasking state machine
`timescale 1ns / 1ps

module wsfd_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [wsfd_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [wsfd_pkg::LIMIT_W-1:0] i_payload_limit,
    output logic                         o_res_valid,
    output wsfd_pkg::t_result            o_res
);
    import wsfd_pkg::*;

    t_phase             r_phase, n_phase;
    logic               r_fin, n_fin;
    logic [OPC_W-1:0]   r_frame_type, n_frame_type;
    logic               r_mask_present, n_mask_present;
    logic [HLEFT_W-1:0] r_hdr_left, n_hdr_left;
    logic [LIMIT_W-1:0] r_len, n_len;
    logic [KEY_W-1:0]   r_mask_key, n_mask_key;
    logic [MIDX_W-1:0]  r_mask_index, n_mask_index;
    logic [OPC_W-1:0]   r_msg_opc, n_msg_opc;

    logic               hd_go;
    logic [OPC_W-1:0]   hd_opc;
    logic [LEN7_W-1:0]  len7;
    logic [HLEFT_W-1:0] hdr_left_dec;
    logic [BYTE_W-1:0]  key_byte;
    logic               pay_last;

    assign len7         = i_data_byte[LEN7_W-1:0];
    assign hdr_left_dec = r_hdr_left - HLEFT_W'(1);
    // the byte of the key for this position, first key byte is the top one
    assign key_byte     = r_mask_present ? r_mask_key[{~r_mask_index, 3'b000} +: BYTE_W]
                                         : '0;
    assign pay_last     = (r_len == LIMIT_W'(1));
    assign hd_opc       = (r_frame_type != OP_CONT && r_msg_opc == OP_CONT) ? r_frame_type
                                                                            : r_msg_opc;

    always_comb begin
        n_phase        = r_phase;
        n_fin          = r_fin;
        n_frame_type   = r_frame_type;
        n_mask_present = r_mask_present;
        n_hdr_left     = r_hdr_left;
        n_len          = r_len;
        n_mask_key     = r_mask_key;
        n_mask_index   = r_mask_index;
        n_msg_opc      = r_msg_opc;
        hd_go          = 1'b0;
        o_res_valid    = 1'b0;
        o_res          = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_fin        = i_data_byte[7];
                    n_frame_type = i_data_byte[OPC_W-1:0];
                    if (i_data_byte[OPC_W-1:0] == OP_CLOSE) begin
                        n_phase            = PH_CLOSED;
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_CLOSE;
                        o_res.message_type = OP_CLOSE;
                    end else begin
                        n_phase = PH_HDR1;
                    end
                end
                PH_HDR1: begin
                    n_mask_present = i_data_byte[7];
                    n_mask_key     = '0;
                    if (len7 == LEN16_CODE || len7 == LEN64_CODE) begin
                        n_len      = '0;
                        n_hdr_left = (len7 == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
                        n_phase    = PH_EXTLEN;
                    end else begin
                        n_len = LIMIT_W'(len7);
                        if (i_data_byte[7]) begin
                            n_hdr_left = KEY_BYTES;
                            n_phase    = PH_MASKKEY;
                        end else begin
                            hd_go = 1'b1;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_len      = {r_len[LIMIT_W-BYTE_W-1:0], i_data_byte};
                    n_hdr_left = hdr_left_dec;
                    if (hdr_left_dec == '0) begin
                        if (r_mask_present) begin
                            n_hdr_left = KEY_BYTES;
                            n_phase    = PH_MASKKEY;
                        end else begin
                            hd_go = 1'b1;
                        end
                    end
                end
                PH_MASKKEY: begin
                    n_mask_key = {r_mask_key[KEY_W-BYTE_W-1:0], i_data_byte};
                    n_hdr_left = hdr_left_dec;
                    if (hdr_left_dec == '0) begin
                        hd_go = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_mask_index       = r_mask_index + MIDX_W'(1);
                    n_len              = r_len - LIMIT_W'(1);
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.payload_byte = i_data_byte ^ key_byte;
                    o_res.frame_last   = pay_last;
                    o_res.message_end  = pay_last & r_fin;
                    o_res.message_type = r_msg_opc;
                    if (pay_last) begin
                        n_phase = PH_HDR0;
                        if (r_fin) begin
                            n_msg_opc = OP_CONT;
                        end
                    end
                end
                PH_SKIP: begin
                    n_len = r_len - LIMIT_W'(1);
                    if (pay_last) begin
                        n_phase = PH_HDR0;
                    end
                end
                PH_CLOSED: begin
                    n_phase = PH_CLOSED;
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // header complete: pick payload, skip or empty/oversize report
            if (hd_go) begin
                n_mask_index = '0;
                if (r_frame_type > OP_BINARY) begin
                    n_phase = (n_len != '0) ? PH_SKIP : PH_HDR0;
                end else begin
                    n_msg_opc = hd_opc;
                    if (n_len > i_payload_limit || n_len == '0) begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = (n_len == '0) ? KIND_EMPTY : KIND_OVERSIZE;
                        o_res.frame_last   = 1'b1;
                        o_res.message_end  = r_fin;
                        o_res.message_type = hd_opc;
                        n_phase            = (n_len != '0) ? PH_SKIP : PH_HDR0;
                        if (r_fin) begin
                            n_msg_opc = OP_CONT;
                        end
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_fin          <= 1'b0;
            r_frame_type   <= '0;
            r_mask_present <= 1'b0;
            r_hdr_left     <= '0;
            r_len          <= '0;
            r_mask_key     <= '0;
            r_mask_index   <= '0;
            r_msg_opc      <= OP_CONT;
        end else begin
            r_phase        <= n_phase;
            r_fin          <= n_fin;
            r_frame_type   <= n_frame_type;
            r_mask_present <= n_mask_present;
            r_hdr_left     <= n_hdr_left;
            r_len          <= n_len;
            r_mask_key     <= n_mask_key;
            r_mask_index   <= n_mask_index;
            r_msg_opc      <= n_msg_opc;
        end
    end

endmodule

// ===== hw/rtl/wsfd_skid.sv =====
// two-entry output register with skid stage for the result channel
`timescale 1ns / 1ps

module wsfd_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wsfd_pkg::t_result i_res,
    output logic              o_in_ready,
    output logic              o_valid,
    output wsfd_pkg::t_result o_res,
    input  logic              i_out_ready
);
    import wsfd_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_free;

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end
        if (!out_free && i_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer
// a result is registered in the output register, or in the skid entry while the sink stalls
// throughput: one byte per cycle, limited only by the two-entry output skid stage
// input ready drops only while both output entries hold results the sink has not taken
// reset: synchronous active-low, parser back to the first header byte, limit to all ones
`timescale 1ns / 1ps

module websocket_frame_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wsfd_byte_if.sink          i_in,
    wsfd_cfg_if.sink           i_cfg,
    wsfd_result_if.source      o_out
);
    import wsfd_pkg::*;

    // payload limit register; the user writes it only while the block is idle, not enforced here
    logic [LIMIT_W-1:0] r_payload_limit;

    logic    in_ready;
    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_limit <= '1;
        end else if (i_cfg.valid) begin
            r_payload_limit <= i_cfg.payload_limit;
        end
    end

    // a byte request is taken whenever the skid stage has room
    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid & in_ready;

    // header parse, length check and unmasking, all in one pass per byte
    wsfd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_data_byte     (i_in.data_byte),
        .i_payload_limit (r_payload_limit),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // output register plus skid entry, so a stalled sink does not stall input at once
    wsfd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (res_valid),
        .i_res       (res),
        .o_in_ready  (in_ready),
        .o_valid     (o_out.valid),
        .o_res       (out_res),
        .i_out_ready (o_out.ready)
    );

    assign o_out.result_kind  = out_res.kind;
    assign o_out.payload_byte = out_res.payload_byte;
    assign o_out.frame_last   = out_res.frame_last;
    assign o_out.message_end  = out_res.message_end;
    assign o_out.message_type = out_res.message_type;

    // close report carries the close opcode and never ends a frame
    a_close_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == KIND_CLOSE) |->
        (!o_out.frame_last && !o_out.message_end && o_out.message_type == OP_CLOSE))
        else $error("close result with bad fields");

    // end of message only ever comes with end of frame
    a_mend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.message_end) |-> o_out.frame_last)
        else $error("message end without frame end");

    // input back-pressure only while a result is waiting on the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with empty output");

    // a stall of the sink with a full skid stage holds the input off next cycle
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in.ready && !o_out.ready) |=> !i_in.ready)
        else $error("skid entry lost under stall");

endmodule

// ===== dv/websocket_frame_deframer_checker.sv =====
// checker that predicts and compares the results of the websocket frame deframer
`timescale 1ns / 1ps

module websocket_frame_deframer_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    wsfd_byte_if    i_in,
    wsfd_cfg_if     i_cfg,
    wsfd_result_if  i_out,
    output int      o_errors,
    output int      o_pending
);
    import wsfd_pkg::*;

    localparam logic [OPC_W-1:0] NO_MESSAGE = 4'h0;

    // parser state of the predictor
    t_phase              phase;
    logic                fin_bit;
    logic [OPC_W-1:0]    frame_op;
    logic                masked;
    logic [HLEFT_W-1:0]  hdr_left;
    logic [LIMIT_W-1:0]  remaining;
    logic [KEY_W-1:0]    mask_word;
    logic [MIDX_W-1:0]   key_pos;
    logic [OPC_W-1:0]    message_op;
    logic [LIMIT_W-1:0]  limit;

    t_result awaited_results[$];
    int      errors;

    initial begin
        errors    = 0;
        o_errors  = 0;
        o_pending = 0;
    end

    // last header byte taken: decide between payload, skip or a single report
    function automatic bit header_complete(output t_result r);
        r = '0;
        key_pos = '0;
        if (frame_op > OP_BINARY) begin
            phase = (remaining != 0) ? PH_SKIP : PH_HDR0;
            return 1'b0;
        end
        if (frame_op != OP_CONT && message_op == NO_MESSAGE)
            message_op = frame_op;
        if (remaining > limit || remaining == 0) begin
            r.kind         = (remaining == 0) ? KIND_EMPTY : KIND_OVERSIZE;
            r.frame_last   = 1'b1;
            r.message_end  = fin_bit;
            r.message_type = message_op;
            phase = (remaining != 0) ? PH_SKIP : PH_HDR0;
            if (fin_bit)
                message_op = NO_MESSAGE;
            return 1'b1;
        end
        phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_result r);
        logic [LEN7_W-1:0] len7;
        logic [BYTE_W-1:0] key_b;
        r = '0;
        case (phase)
            PH_HDR0: begin
                fin_bit  = b[7];
                frame_op = b[OPC_W-1:0];
                if (frame_op == OP_CLOSE) begin
                    phase = PH_CLOSED;
                    r.kind         = KIND_CLOSE;
                    r.message_type = OP_CLOSE;
                    return 1'b1;
                end
                phase = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1: begin
                len7      = b[LEN7_W-1:0];
                masked    = b[7];
                mask_word = '0;
                remaining = '0;
                if (len7 == LEN16_CODE || len7 == LEN64_CODE) begin
                    hdr_left = (len7 == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
                    phase    = PH_EXTLEN;
                    return 1'b0;
                end
                remaining = LIMIT_W'(len7);
                if (masked) begin
                    hdr_left = KEY_BYTES;
                    phase    = PH_MASKKEY;
                    return 1'b0;
                end
                return header_complete(r);
            end
            PH_EXTLEN: begin
                remaining = {remaining[LIMIT_W-BYTE_W-1:0], b};
                hdr_left  = hdr_left - 1'b1;
                if (hdr_left != 0)
                    return 1'b0;
                if (masked) begin
                    hdr_left = KEY_BYTES;
                    phase    = PH_MASKKEY;
                    return 1'b0;
                end
                return header_complete(r);
            end
            PH_MASKKEY: begin
                mask_word = {mask_word[KEY_W-BYTE_W-1:0], b};
                hdr_left  = hdr_left - 1'b1;
                if (hdr_left != 0)
                    return 1'b0;
                return header_complete(r);
            end
            PH_PAYLOAD: begin
                // key bytes are applied in network order, first byte first
                key_b = masked ? mask_word[31 - 8 * key_pos -: 8] : '0;
                key_pos   = key_pos + 1'b1;
                remaining = remaining - 1'b1;
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b ^ key_b;
                r.frame_last   = (remaining == 0);
                r.message_end  = (remaining == 0) && fin_bit;
                r.message_type = message_op;
                if (remaining == 0) begin
                    phase = PH_HDR0;
                    if (fin_bit)
                        message_op = NO_MESSAGE;
                end
                return 1'b1;
            end
            PH_SKIP: begin
                remaining = remaining - 1'b1;
                if (remaining == 0)
                    phase = PH_HDR0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_result exp_r;
        t_result got_r;
        t_result new_r;
        if (!i_rst_n) begin
            phase      = PH_HDR0;
            fin_bit    = 1'b0;
            frame_op   = '0;
            masked     = 1'b0;
            hdr_left   = '0;
            remaining  = '0;
            mask_word  = '0;
            key_pos    = '0;
            message_op = NO_MESSAGE;
            limit      = '1;
            awaited_results.delete();
        end else begin
            // results first: a byte taken at this edge cannot show before the next one
            if (i_out.valid && i_out.ready) begin
                got_r.kind         = t_kind'(i_out.result_kind);
                got_r.payload_byte = i_out.payload_byte;
                got_r.frame_last   = i_out.frame_last;
                got_r.message_end  = i_out.message_end;
                got_r.message_type = i_out.message_type;
                if (awaited_results.size() == 0) begin
                    if (errors < 10)
                        $display("%t unexpected result kind=%0d byte=%h last=%b end=%b type=%h",
                                 $realtime, got_r.kind, got_r.payload_byte, got_r.frame_last,
                                 got_r.message_end, got_r.message_type);
                    errors++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (got_r !== exp_r) begin
                        if (errors < 10) begin
                            $display("%t result mismatch: expected kind=%0d byte=%h last=%b end=%b type=%h",
                                     $realtime, exp_r.kind, exp_r.payload_byte,
                                     exp_r.frame_last, exp_r.message_end, exp_r.message_type);
                            $display("%t   got kind=%0d byte=%h last=%b end=%b type=%h",
                                     $realtime, got_r.kind, got_r.payload_byte,
                                     got_r.frame_last, got_r.message_end, got_r.message_type);
                        end
                        errors++;
                    end
                end
            end
            // a byte taken at this edge still sees the old limit
            if (i_in.valid && i_in.ready) begin
                if (deframe_byte(i_in.data_byte, new_r))
                    awaited_results.push_back(new_r);
            end
            if (i_cfg.valid && i_cfg.ready)
                limit = i_cfg.payload_limit;
        end
        o_errors  <= errors;
        o_pending <= awaited_results.size();
    end

endmodule

// ===== dv/websocket_frame_deframer_test.sv =====
// stimulus, stall patterns and verdict for the websocket frame deframer
`timescale 1ns / 1ps

module websocket_frame_deframer_test;
    import wsfd_pkg::*;

    // opcodes used only by the stimulus
    localparam logic [OPC_W-1:0] OP_TEXT     = 4'h1;
    localparam logic [OPC_W-1:0] OP_PING     = 4'h9;
    localparam logic [OPC_W-1:0] OP_PONG     = 4'hA;
    localparam logic [OPC_W-1:0] OP_RSV_DATA = 4'h3;   // first reserved data opcode
    localparam logic [OPC_W-1:0] OP_RSV_CTRL = 4'hB;   // first reserved control opcode

    localparam int RANDOM_BYTES = 500;

    // how the payload length is carried in the header
    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } t_len_form;

    logic               i_clk;
    logic               i_rst_n;
    int                 err_count;
    int                 pending_count;
    int                 burst_left;
    bit                 steady_phase;
    int unsigned        random_count;

    wsfd_byte_if   in_ch ();
    wsfd_cfg_if    cfg_ch ();
    wsfd_result_if out_ch ();

    websocket_frame_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    websocket_frame_deframer_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_cfg     (cfg_ch),
        .i_out     (out_ch),
        .o_errors  (err_count),
        .o_pending (pending_count)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // result sink: switches between free flow, light and heavy random stalls,
    // and a fixed duty pattern, each mode held for a random stretch
    int unsigned sink_mode;
    int unsigned sink_left;
    int unsigned sink_cycle;

    initial begin
        sink_mode  = 0;
        sink_left  = 0;
        sink_cycle = 0;
    end

    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(32, 400);
        end else begin
            sink_left--;
        end
        sink_cycle++;
        case (sink_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ((sink_cycle % 7) < 4);
        endcase
    end

    // one byte request; the sender runs in bursts with idle gaps between them.
    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (steady_phase || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_ch.valid     <= 1'b0;
                in_ch.data_byte <= BYTE_W'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // stop sending and let every awaited result drain before returning
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        settle();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.payload_limit <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one complete frame with random key and payload; counted returns the
    // number of bytes sent for the frame, skipped payload included
    task automatic send_frame(input logic fin, input logic [2:0] rsv,
                              input logic [OPC_W-1:0] op, input logic mask_on,
                              input int unsigned len, input t_len_form form,
                              output int unsigned counted);
        logic [KEY_W-1:0]   key;
        logic [LIMIT_W-1:0] len64;
        int                 i;
        int unsigned        r;
        key     = $urandom;
        len64   = LIMIT_W'(len);
        counted = 2;
        if (form == LEN_SHORT && len > 125)
            form = LEN_EXT16;
        push_byte({fin, rsv, op});
        case (form)
            LEN_SHORT: push_byte({mask_on, LEN7_W'(len)});
            LEN_EXT16: begin
                push_byte({mask_on, LEN16_CODE});
                push_byte(len64[15:8]);
                push_byte(len64[7:0]);
                counted += 2;
            end
            default: begin
                push_byte({mask_on, LEN64_CODE});
                for (i = 7; i >= 0; i--)
                    push_byte(len64[8 * i +: 8]);
                counted += 8;
            end
        endcase
        if (mask_on) begin
            for (i = 3; i >= 0; i--)
                push_byte(key[8 * i +: 8]);
            counted += 4;
        end
        // payload leans toward all-zero and all-one bytes now and then
        for (i = 0; i < int'(len); i++) begin
            r = $urandom_range(0, 7);
            push_byte(r == 0 ? 8'h00 : r == 1 ? 8'hFF : BYTE_W'($urandom));
        end
        counted += len;
    endtask

    initial begin : stimulus
        int unsigned    counted;
        int unsigned    frames;
        int unsigned    r;
        int unsigned    len;
        int             i;
        bit             in_msg;
        logic           fin;
        logic           mask_on;
        logic [2:0]     rsv;
        logic [OPC_W-1:0] op;
        t_len_form      form;

        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.payload_limit = '0;
        out_ch.ready         = 1'b0;
        burst_left           = 0;
        steady_phase         = 1'b0;
        random_count         = 0;
        in_msg               = 1'b0;

        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, limit at its reset value of all ones
        // text start without fin, then a masked continuation
        send_frame(1'b0, 3'b000, OP_TEXT, 1'b0, 3, LEN_SHORT, counted);
        send_frame(1'b0, 3'b000, OP_CONT, 1'b1, 2, LEN_SHORT, counted);
        // ping with reserved bits set in the middle of the message: dropped
        send_frame(1'b1, 3'b111, OP_PING, 1'b1, 2, LEN_SHORT, counted);
        // empty final continuation ends the text message
        send_frame(1'b1, 3'b000, OP_CONT, 1'b0, 0, LEN_SHORT, counted);
        // all-ones first header byte: reserved control opcode, 16-bit length
        send_frame(1'b1, 3'b111, 4'hF, 1'b1, 1, LEN_EXT16, counted);
        // continuation with no message started
        send_frame(1'b1, 3'b000, OP_CONT, 1'b0, 1, LEN_SHORT, counted);
        // binary frame with a 64-bit length field
        send_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 2, LEN_EXT64, counted);

        // zero limit: every non-empty data frame is oversize
        write_limit('0);
        send_frame(1'b1, 3'b000, OP_BINARY, 1'b0, 1, LEN_SHORT, counted);
        send_frame(1'b0, 3'b000, OP_TEXT, 1'b0, 0, LEN_SHORT, counted);
        send_frame(1'b1, 3'b000, OP_CONT, 1'b1, 2, LEN_SHORT, counted);
        send_frame(1'b1, 3'b000, OP_PONG, 1'b0, 0, LEN_SHORT, counted);
        // 16-bit length using both length bytes, skipped in full
        send_frame(1'b1, 3'b000, OP_BINARY, 1'b0, 300, LEN_EXT16, counted);

        // length right at the limit is taken, one above is skipped
        write_limit(64'd3);
        send_frame(1'b1, 3'b000, OP_BINARY, 1'b0, 3, LEN_SHORT, counted);
        send_frame(1'b1, 3'b000, OP_TEXT, 1'b1, 4, LEN_SHORT, counted);

        // random part: phases of well-formed messages with random content,
        // mixed with control frames, reserved opcodes and broken sequences
        while (random_count < RANDOM_BYTES) begin
            case ($urandom_range(0, 4))
                0: write_limit('1);
                1: write_limit('0);
                2, 3: write_limit(LIMIT_W'($urandom_range(0, 40)));
                default: write_limit({$urandom, $urandom});
            endcase
            steady_phase = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(2, 12);
            repeat (frames) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    r = $urandom_range(0, 11);
                    if (r < 4)
                        op = OP_PING;
                    else if (r < 7)
                        op = OP_PONG;
                    else if (r < 9)
                        op = OP_RSV_DATA + OPC_W'($urandom_range(0, 4));
                    else
                        op = OP_RSV_CTRL + OPC_W'($urandom_range(0, 4));
                    fin = ($urandom_range(0, 3) != 0);
                end else if (in_msg) begin
                    op  = (r <= 7) ? OP_CONT : ($urandom_range(0, 1) ? OP_TEXT : OP_BINARY);
                    fin = $urandom_range(0, 1);
                end else begin
                    op  = (r <= 8) ? ($urandom_range(0, 1) ? OP_TEXT : OP_BINARY) : OP_CONT;
                    fin = ($urandom_range(0, 2) == 0);
                end
                if (op <= OP_BINARY)
                    in_msg = !fin;
                rsv     = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'b000;
                mask_on = $urandom_range(0, 1);
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    len  = $urandom_range(0, 15);
                    form = LEN_SHORT;
                end else if (r < 80) begin
                    len  = $urandom_range(16, 125);
                    form = LEN_SHORT;
                end else if (r < 90) begin
                    len  = $urandom_range(0, 300);
                    form = LEN_EXT16;
                end else begin
                    len  = $urandom_range(0, 300);
                    form = LEN_EXT64;
                end
                send_frame(fin, rsv, op, mask_on, len, form, counted);
                random_count += counted;
                if (random_count >= RANDOM_BYTES)
                    break;
            end
        end

        // the run ends on a state that only reset leaves: either a close frame,
        // or a 64-bit length with its top bit set that never runs out
        if ($urandom_range(0, 1)) begin
            push_byte({1'b1, 3'($urandom), OP_CLOSE});
            // everything after the close is ignored, a second close too
            push_byte({1'b1, 3'b000, OP_CLOSE});
            repeat ($urandom_range(2, 8))
                push_byte(BYTE_W'($urandom));
        end else begin
            write_limit($urandom_range(0, 1) ? '1 : LIMIT_W'($urandom_range(0, 200)));
            push_byte({1'b1, 3'b000, OP_BINARY});
            push_byte({1'b0, LEN64_CODE});
            push_byte({1'b1, 7'($urandom)});
            for (i = 0; i < 7; i++)
                push_byte(BYTE_W'($urandom));
            repeat (6)
                push_byte(BYTE_W'($urandom));
        end

        // drain the awaited results, then give the verdict
        in_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (err_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest run with every gap and stall at its worst
    initial begin
        #(12_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
